@@ rtl/dfam_pkg.sv @@
// ============================================================================
// dfam_pkg
// Shared types and constants of the table-driven DFA matcher.
// ============================================================================
`default_nettype none

package dfam_pkg;

    // Default table geometry
    localparam int NUM_STATES_DEF  = 128;
    localparam int NUM_SYMBOLS_DEF = 256;

    // Fixed field widths
    localparam int STATE_W = 7;
    localparam int SYM_W   = 8;

    // Stream payload widths (tdata in whole bytes)
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;

    // Result queue depth; also the credit limit on items in flight
    localparam int RES_DEPTH   = 4;
    localparam int RES_PTR_W   = 2;
    localparam int RES_CNT_W   = 3;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_START_STATE = 1'b0;   // register index, paddr[2]

    // Item kinds carried on tuser
    typedef enum logic [1:0] {
        FUNC_LINK      = 2'd0,
        FUNC_SET_ACC   = 2'd1,
        FUNC_SYMBOL    = 2'd2,
        FUNC_EMPTY_END = 2'd3
    } func_t;

    // One match result
    typedef struct packed {
        logic [STATE_W-1:0] final_state;
        logic               accepted;
    } res_t;

    // Clearing sequencer status
    typedef struct packed {
        logic active;
        logic last;
    } clr_stat_t;

endpackage : dfam_pkg

`default_nettype wire

@@ rtl/dfam_ram.sv @@
// ============================================================================
// dfam_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// A read at the address being written returns the old data.
// ============================================================================
`default_nettype none

module dfam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : dfam_ram

`default_nettype wire

@@ rtl/dfam_clear.sv @@
// ============================================================================
// dfam_clear
// Post-reset clearing sequencer: sweeps every table address once, one per
// cycle, then stays done until the next reset.
// ============================================================================
`default_nettype none

module dfam_clear
    import dfam_pkg::*;
#(
    parameter int ADDR_W = 15
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    output clr_stat_t              stat,
    output logic      [ADDR_W-1:0] addr
);

    logic              active_reg, active_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;

    // Sweep control
    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        if (active_reg)
        begin
            cnt_next = cnt_reg + ADDR_W'(1);
            if (&cnt_reg)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign stat.active = active_reg;
    assign stat.last   = active_reg & (&cnt_reg);
    assign addr        = cnt_reg;

endmodule : dfam_clear

`default_nettype wire

@@ rtl/dfam_resq.sv @@
// ============================================================================
// dfam_resq
// Small result queue in front of the master stream; its fill level feeds the
// input credit check so the read pipeline never has to stall.
// ============================================================================
`default_nettype none

module dfam_resq
    import dfam_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire res_t                 push_data,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output res_t                      head,
    output logic      [RES_CNT_W-1:0] count
);

    res_t                 entry [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [RES_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 pop;

    assign pop = m_axis_tvalid & m_axis_tready;

    // Fill level
    always_comb
    begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + RES_CNT_W'(1);
            2'b01:   cnt_next = cnt_reg - RES_CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + RES_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + RES_PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry[wr_ptr_reg] <= push_data;
        end
    end

    assign m_axis_tvalid = (cnt_reg != '0);
    assign head          = entry[rd_ptr_reg];
    assign count         = cnt_reg;

endmodule : dfam_resq

`default_nettype wire

@@ rtl/table_driven_dfa_matcher.sv @@
// ============================================================================
// table_driven_dfa_matcher
// Table-driven DFA string matcher: a transition table and accepting bits in
// synchronous RAM, one symbol lookup per cycle.
// ============================================================================
//
//  channel   dir  handshake                 payload
//  --------  ---  ------------------------  -----------------------------------
//  s_axis    in   tvalid / tready           tdata, tuser (item kind), tlast
//  m_axis    out  tvalid / tready           tdata (match result)
//  apb       in   psel / penable / pready   paddr, pwdata, prdata (start_state)
//
//  One item per cycle while s_axis_tready is high, any mix of kinds. A result
//  passes stage 1, stage 2 and the result queue; the table RAM read whose data
//  feeds the next read address sets the one-symbol-per-cycle rate.
//  After reset the table and accepting bits are cleared by a sweep of all
//  NUM_STATES_P2 * NUM_SYMBOLS_P2 entries (32768 by default; sizes rounded
//  up to powers of two); s_axis_tready stays low meanwhile, APB writes work.
//  Up to RES_DEPTH results may be pending; s_axis_tready drops when a stalled
//  m_axis would otherwise overflow.
// ============================================================================
`default_nettype none

module table_driven_dfa_matcher
    import dfam_pkg::*;
#(
    parameter int NUM_STATES  = NUM_STATES_DEF,
    parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input items
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // state_index[6:0], to_state[13:7], symbol[21:14], accepting_flag[22], pad
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // func[1:0]
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    // is_last
    input  wire logic                   s_axis_tlast,
    // results
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // accepted[0], final_state[7:1]
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
    // configuration
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_AW-1:0]      paddr,
    input  wire logic [APB_DW-1:0]      pwdata,
    output logic      [APB_DW-1:0]      prdata,
    output logic                        pready
);

    localparam int STW   = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int SYW   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int TAW   = STW + SYW;
    localparam int TDEP  = 1 << TAW;
    localparam int ADEP  = 1 << STW;

    // ---------------------------------------------------------------- config
    logic [STATE_W-1:0] start_reg;
    logic               cfg_wr;
    logic               cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[APB_AW-1] == REG_START_STATE);
    assign cfg_wr  = psel & penable & pwrite & pready & cfg_hit;
    assign prdata  = cfg_hit ? APB_DW'(start_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else if (cfg_wr)
        begin
            start_reg <= pwdata[STATE_W-1:0];
        end
    end

    // ---------------------------------------------------------- input fields
    func_t              func;
    logic [STATE_W-1:0] in_state;
    logic [STATE_W-1:0] in_to;
    logic [SYM_W-1:0]   in_sym;
    logic               in_flag;
    logic               in_xfer;

    assign func     = func_t'(s_axis_tuser);
    assign in_state = s_axis_tdata[6:0];
    assign in_to    = s_axis_tdata[13:7];
    assign in_sym   = s_axis_tdata[21:14];
    assign in_flag  = s_axis_tdata[22];
    assign in_xfer  = s_axis_tvalid & s_axis_tready;

    logic is_link, is_set, is_sym, is_empty;

    // Item kind decode
    always_comb
    begin
        is_link  = 1'b0;
        is_set   = 1'b0;
        is_sym   = 1'b0;
        is_empty = 1'b0;
        unique case (func)
            FUNC_LINK:      is_link  = in_xfer;
            FUNC_SET_ACC:   is_set   = in_xfer;
            FUNC_SYMBOL:    is_sym   = in_xfer;
            FUNC_EMPTY_END: is_empty = in_xfer;
            default:        is_link  = 1'b0;
        endcase
    end

    // --------------------------------------------------------- clear sweep
    clr_stat_t          clr;
    logic [TAW-1:0]     clr_addr;

    dfam_clear #(
        .ADDR_W (TAW)
    ) u_clear (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (clr),
        .addr  (clr_addr)
    );

    // ------------------------------------------------------ string tracking
    logic               mid_reg;
    logic [STATE_W-1:0] cur_reg;
    logic               s1_sym_reg, s1_res_reg, s1_empty_reg;
    logic               s1_oor_reg, s1_start_oor_reg;
    logic [STATE_W-1:0] s1_start_reg;
    logic [STATE_W-1:0] s1_next;
    logic [STATE_W-1:0] tbl_rdata;
    logic [STATE_W-1:0] src_state;

    // Source state: forward the lookup still in flight
    always_comb
    begin
        if (!mid_reg)
        begin
            src_state = start_reg;
        end
        else if (s1_sym_reg)
        begin
            src_state = s1_next;
        end
        else
        begin
            src_state = cur_reg;
        end
    end

    // Range checks and table addresses
    logic [31:0]    src_ext, st_ext, sym_ext, start_ext;
    logic           src_ok, st_ok, sym_ok, to_ok, start_ok;
    logic [TAW-1:0] rd_addr, lk_addr;

    assign src_ext   = 32'(src_state);
    assign st_ext    = 32'(in_state);
    assign sym_ext   = 32'(in_sym);
    assign start_ext = 32'(start_reg);
    assign src_ok    = src_ext < 32'(NUM_STATES);
    assign st_ok     = st_ext < 32'(NUM_STATES);
    assign sym_ok    = sym_ext < 32'(NUM_SYMBOLS);
    assign to_ok     = 32'(in_to) < 32'(NUM_STATES);
    assign start_ok  = start_ext < 32'(NUM_STATES);
    assign rd_addr   = {src_ext[STW-1:0], sym_ext[SYW-1:0]};
    assign lk_addr   = {st_ext[STW-1:0], sym_ext[SYW-1:0]};

    // Transition table write: clear sweep or link item
    logic               tbl_we;
    logic [TAW-1:0]     tbl_waddr;
    logic [STATE_W-1:0] tbl_wdata;

    assign tbl_we    = clr.active | (is_link & st_ok & sym_ok);
    assign tbl_waddr = clr.active ? clr_addr : lk_addr;
    assign tbl_wdata = (clr.active || !to_ok) ? '0 : in_to;

    dfam_ram #(
        .WIDTH (STATE_W),
        .DEPTH (TDEP)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (rd_addr),
        .rdata (tbl_rdata)
    );

    // Stage 1: lookup result, zero if out of range, or start state for an empty string
    always_comb
    begin
        if (s1_empty_reg)
        begin
            s1_next = s1_start_reg;
        end
        else if (s1_oor_reg)
        begin
            s1_next = '0;
        end
        else
        begin
            s1_next = tbl_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg      <= 1'b0;
            cur_reg      <= '0;
            s1_sym_reg   <= 1'b0;
            s1_res_reg   <= 1'b0;
            s1_empty_reg <= 1'b0;
        end
        else
        begin
            if (is_sym)
            begin
                mid_reg <= ~s_axis_tlast;
            end
            else if (is_empty)
            begin
                mid_reg <= 1'b0;
            end
            if (s1_sym_reg)
            begin
                cur_reg <= s1_next;
            end
            s1_sym_reg   <= is_sym;
            s1_res_reg   <= (is_sym & s_axis_tlast) | is_empty;
            s1_empty_reg <= is_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_oor_reg       <= ~(src_ok & sym_ok);
        s1_start_reg     <= start_reg;
        s1_start_oor_reg <= ~start_ok;
    end

    // ------------------------------------------------------- accepting bits
    logic           acc_we;
    logic [STW-1:0] acc_waddr;
    logic           acc_wdata;
    logic [31:0]    next_ext;
    logic           acc_rdata;

    assign next_ext  = 32'(s1_next);
    assign acc_we    = clr.active | (is_set & st_ok);
    assign acc_waddr = clr.active ? clr_addr[STW-1:0] : st_ext[STW-1:0];
    assign acc_wdata = ~clr.active & in_flag;

    dfam_ram #(
        .WIDTH (1),
        .DEPTH (ADEP)
    ) u_accept (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (next_ext[STW-1:0]),
        .rdata (acc_rdata)
    );

    // Stage 2: accepting bit lookup
    logic               s2_valid_reg;
    logic               s2_oor_reg;
    logic [STATE_W-1:0] s2_state_reg;
    res_t               s2_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_state_reg <= s1_next;
        s2_oor_reg   <= s1_empty_reg & s1_start_oor_reg;
    end

    assign s2_res.final_state = s2_state_reg;
    assign s2_res.accepted    = acc_rdata & ~s2_oor_reg;

    // ------------------------------------------------------------ result out
    res_t                 head;
    logic [RES_CNT_W-1:0] q_count;
    logic [RES_CNT_W:0]   pending;

    dfam_resq u_resq (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (s2_valid_reg),
        .push_data     (s2_res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .head          (head),
        .count         (q_count)
    );

    assign m_axis_tdata = {head.final_state, head.accepted};

    // Credit check: every result in flight has a queue slot
    assign pending = (RES_CNT_W+1)'(q_count) + (RES_CNT_W+1)'(s1_res_reg)
                   + (RES_CNT_W+1)'(s2_valid_reg);
    assign s_axis_tready = ~clr.active & (pending < (RES_CNT_W+1)'(RES_DEPTH));

endmodule : table_driven_dfa_matcher

`default_nettype wire

@@ rtl/dfam_checker.sv @@
// ============================================================================
// dfam_checker
// Port-level checks of the DFA matcher, bound to the top level.
// ============================================================================
`default_nettype none

module dfam_checker
    import dfam_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   psel,
    input wire logic                   penable,
    input wire logic                   pwrite,
    input wire logic                   pready,
    input wire logic [APB_AW-1:0]      paddr,
    input wire logic [APB_DW-1:0]      pwdata,
    input wire logic [APB_DW-1:0]      prdata
);

    // Table clearing holds off input right after reset
    a_clear_after_reset : assert property (@(posedge clk)
        $rose(rst_n) |-> !s_axis_tready)
        else $error("input taken during clearing sweep");

    // A stalled result holds
    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // A result appearing on an empty output stems from an earlier input transfer
    a_out_cause : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 3))
        else $error("result without a matching input transfer");

    // The start state register reads back what was written
    a_cfg_readback : assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr == {REG_START_STATE, 2'b00})
        |=> (paddr != {REG_START_STATE, 2'b00})
            || (prdata == {25'd0, $past(pwdata[6:0])}))
        else $error("start state readback mismatch");

endmodule : dfam_checker

bind table_driven_dfa_matcher dfam_checker u_dfam_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);

`default_nettype wire

@@ verif/table_driven_dfa_matcher_tb.sv @@
// ============================================================================
// table_driven_dfa_matcher_tb
// Self-checking testbench for the table-driven DFA matcher. Items are sent on
// the input stream while a local copy of the transition table, accepting bits
// and string state predicts every match result. Results are checked in order,
// field by field. Both stream sides idle at random, the start_state register
// is written between phases and read back, and the run ends with a pass/fail
// verdict.
// ============================================================================
`timescale 1ns / 100ps

module table_driven_dfa_matcher_tb
    import dfam_pkg::*;
();

    localparam int  CLK_PERIOD   = 12;
    localparam int  RESET_CYCLES = 8;
    localparam int  SETTLE       = 8;        // cycles after the last result
    localparam int  HOLD_CYCLES  = 300;      // long receiver hold-off
    localparam int  CYCLE_LIMIT  = 600000;
    localparam int  RANDOM_ITEMS = 850;

    // DUT ports
    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_AW-1:0]      paddr;
    logic [APB_DW-1:0]      pwdata;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    // Local copy of the matcher state
    logic [STATE_W-1:0] trans_tbl [0:NUM_STATES_DEF*NUM_SYMBOLS_DEF-1];
    logic               acc_bits  [0:NUM_STATES_DEF-1];
    logic [STATE_W-1:0] cur_st;
    logic               in_string;
    logic [STATE_W-1:0] start_st;

    // Match results still to come, oldest first
    res_t pending_matches [$];

    // Stimulus controls
    bit send_gaps;
    bit recv_stalls;
    bit hold_req;

    // Current random automaton
    logic [STATE_W-1:0] dfa_states [0:5];
    logic [SYM_W-1:0]   dfa_alpha  [0:3];
    int                 n_states;
    int                 n_alpha;

    // Bookkeeping
    int errors;
    int items_sent;
    int results_seen;
    int cfg_writes;
    int dfa_phases;
    int cycles;

    res_t               got_res;
    res_t               exp_res;

    table_driven_dfa_matcher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Run limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("table_driven_dfa_matcher_tb failed");
        $finish;
    end

    // Advance the local matcher by one item; queue the result it causes
    function automatic void dfa_apply(input func_t f, input logic [STATE_W-1:0] st,
                                      input logic [STATE_W-1:0] to,
                                      input logic [SYM_W-1:0] sym,
                                      input logic flag, input logic last);
        logic [STATE_W-1:0] src;
        logic [STATE_W-1:0] nxt;
        res_t               r;
        case (f)
            FUNC_LINK:
                trans_tbl[{st, sym}] = to;
            FUNC_SET_ACC:
                acc_bits[st] = flag;
            FUNC_SYMBOL:
            begin
                src    = in_string ? cur_st : start_st;
                nxt    = trans_tbl[{src, sym}];
                cur_st = nxt;
                if (last)
                begin
                    in_string     = 1'b0;
                    r.accepted    = acc_bits[nxt];
                    r.final_state = nxt;
                    pending_matches.push_back(r);
                end
                else
                    in_string = 1'b1;
            end
            default:
            begin
                // empty string end, also abandons an open string
                in_string     = 1'b0;
                r.accepted    = acc_bits[start_st];
                r.final_state = start_st;
                pending_matches.push_back(r);
            end
        endcase
    endfunction

    // Offer one item and wait for its transfer
    task automatic feed_item(input func_t f, input logic [STATE_W-1:0] st,
                             input logic [STATE_W-1:0] to, input logic [SYM_W-1:0] sym,
                             input logic flag, input logic last);
        @(negedge clk);
        if (send_gaps && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, flag, sym, to, st};
        s_axis_tuser  <= f;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        dfa_apply(f, st, to, sym, flag, last);
        items_sent++;
    endtask

    // Stop sending and wait until every predicted result has arrived
    task automatic wait_matches_done();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write start_state, then read it back
    task automatic write_start_state(input logic [STATE_W-1:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_START_STATE, 2'b00};
        pwdata  <= {{(APB_DW-STATE_W){1'b0}}, v};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        start_st = v;
        cfg_writes++;
        // read access
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {{(APB_DW-STATE_W){1'b0}}, v})
        begin
            $error("start_state readback: expected %0d, actual %0d", v, prdata);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random automaton over a few states and symbols
    task automatic build_dfa(input logic [STATE_W-1:0] first_state);
        n_states = $urandom_range(2, 6);
        n_alpha  = $urandom_range(2, 4);
        dfa_states[0] = first_state;
        for (int i = 1; i < n_states; i++)
            dfa_states[i] = 7'($urandom_range(0, 127));
        for (int i = 0; i < n_alpha; i++)
            dfa_alpha[i] = 8'($urandom_range(0, 255));
        for (int s = 0; s < n_states; s++)
        begin
            for (int a = 0; a < n_alpha; a++)
            begin
                feed_item(FUNC_LINK, dfa_states[s],
                          ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127)) :
                              dfa_states[$urandom_range(0, n_states - 1)],
                          dfa_alpha[a], 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
            feed_item(FUNC_SET_ACC, dfa_states[s], 7'($urandom_range(0, 127)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end
        dfa_phases++;
    endtask

    // Strings over the current alphabet, with random noise items when noisy
    task automatic run_strings(input int n_strings, input bit noisy);
        int len;
        for (int s = 0; s < n_strings; s++)
        begin
            len = $urandom_range(0, 8);
            if (len == 0)
                feed_item(FUNC_EMPTY_END, 7'($urandom_range(0, 127)),
                          7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            for (int i = 0; i < len; i++)
            begin
                if (noisy && $urandom_range(0, 9) == 0)
                    feed_item(func_t'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                              7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                feed_item(FUNC_SYMBOL, 7'($urandom_range(0, 127)),
                          7'($urandom_range(0, 127)),
                          (noisy && $urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) :
                              dfa_alpha[$urandom_range(0, n_alpha - 1)],
                          1'($urandom_range(0, 1)), i == len - 1);
            end
        end
    endtask

    // Cleared table: every string lands in the dead state, nothing accepts
    task automatic test_cleared_table();
        feed_item(FUNC_SYMBOL, 7'd0, 7'd0, 8'd0, 1'b0, 1'b1);
        feed_item(FUNC_SYMBOL, 7'd127, 7'd127, 8'd255, 1'b1, 1'b1);
        feed_item(FUNC_EMPTY_END, 7'd0, 7'd0, 8'd0, 1'b0, 1'b0);
        wait_matches_done();
    endtask

    // Hand-built automaton: field extremes, abandoned strings, start change
    task automatic test_directed_dfa();
        write_start_state(7'd127);
        feed_item(FUNC_SET_ACC, 7'd127, 7'd0, 8'd0, 1'b1, 1'b0);
        feed_item(FUNC_LINK, 7'd127, 7'd127, 8'd255, 1'b0, 1'b0);
        // is_last on a link causes no result
        feed_item(FUNC_LINK, 7'd127, 7'd5, 8'd0, 1'b1, 1'b1);
        feed_item(FUNC_SET_ACC, 7'd5, 7'd127, 8'd255, 1'b1, 1'b0);
        feed_item(FUNC_SET_ACC, 7'd5, 7'd0, 8'd0, 1'b0, 1'b0);
        feed_item(FUNC_EMPTY_END, 7'd127, 7'd127, 8'd255, 1'b1, 1'b1);
        feed_item(FUNC_SYMBOL, 7'd0, 7'd0, 8'd255, 1'b0, 1'b1);
        feed_item(FUNC_SYMBOL, 7'd0, 7'd0, 8'd255, 1'b0, 1'b0);
        feed_item(FUNC_SYMBOL, 7'd0, 7'd0, 8'd0, 1'b0, 1'b1);
        // empty end in the middle of a string drops the string
        feed_item(FUNC_SYMBOL, 7'd0, 7'd0, 8'd255, 1'b0, 1'b0);
        feed_item(FUNC_EMPTY_END, 7'd0, 7'd0, 8'd0, 1'b0, 1'b0);
        feed_item(FUNC_SYMBOL, 7'd0, 7'd0, 8'd0, 1'b0, 1'b1);
        // new start state does not affect a string already open
        feed_item(FUNC_LINK, 7'd5, 7'd42, 8'h55, 1'b0, 1'b0);
        feed_item(FUNC_SYMBOL, 7'd0, 7'd0, 8'd0, 1'b0, 1'b0);
        wait_matches_done();
        write_start_state(7'd0);
        feed_item(FUNC_SYMBOL, 7'd0, 7'd0, 8'h55, 1'b0, 1'b1);
        feed_item(FUNC_SET_ACC, 7'd0, 7'd0, 8'd0, 1'b1, 1'b0);
        feed_item(FUNC_EMPTY_END, 7'd0, 7'd0, 8'd0, 1'b0, 1'b0);
        feed_item(FUNC_SYMBOL, 7'd0, 7'd0, 8'd1, 1'b0, 1'b1);
        feed_item(FUNC_SET_ACC, 7'd0, 7'd0, 8'd0, 1'b0, 1'b0);
        wait_matches_done();
    endtask

    // Random automata with random start states, 0 and 127 among them
    task automatic test_random_dfas();
        logic [STATE_W-1:0] first;
        int                 phase;
        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            first = (phase == 0) ? 7'd0 : (phase == 1) ? 7'd127 : 7'($urandom_range(0, 127));
            wait_matches_done();
            write_start_state(first);
            build_dfa(first);
            run_strings($urandom_range(15, 30), 1'b1);
            phase++;
        end
        wait_matches_done();
    endtask

    // Receiver holds off long enough for the block to stall its input
    task automatic test_output_hold();
        send_gaps = 1'b0;
        hold_req  = 1'b1;
        for (int i = 0; i < 40; i++)
            feed_item(FUNC_SYMBOL, 7'd0, 7'd0, dfa_alpha[$urandom_range(0, n_alpha - 1)],
                      1'b0, 1'b1);
        send_gaps = 1'b1;
        wait_matches_done();
    endtask

    // Back-to-back transfers on both sides
    task automatic test_full_rate();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        run_strings(25, 1'b0);
        wait_matches_done();
    endtask

    // Receiver ready: random stall bursts, plus one long hold on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (recv_stalls && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Result check against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_res = res_t'(m_axis_tdata);
            results_seen++;
            if (pending_matches.size() == 0)
            begin
                $error("unexpected result transfer: tdata %0h", m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_res = pending_matches.pop_front();
                if (got_res.accepted !== exp_res.accepted)
                begin
                    $error("accepted: expected %0d, actual %0d",
                           exp_res.accepted, got_res.accepted);
                    errors++;
                end
                if (got_res.final_state !== exp_res.final_state)
                begin
                    $error("final_state: expected %0d, actual %0d",
                           exp_res.final_state, got_res.final_state);
                    errors++;
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        send_gaps     = 1'b1;
        recv_stalls   = 1'b1;
        hold_req      = 1'b0;
        errors        = 0;
        items_sent    = 0;
        results_seen  = 0;
        cfg_writes    = 0;
        dfa_phases    = 0;
        for (int i = 0; i < NUM_STATES_DEF * NUM_SYMBOLS_DEF; i++)
            trans_tbl[i] = '0;
        for (int i = 0; i < NUM_STATES_DEF; i++)
            acc_bits[i] = 1'b0;
        cur_st    = '0;
        in_string = 1'b0;
        start_st  = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // stream input waits out the table clearing sweep by itself
        test_cleared_table();
        test_directed_dfa();
        test_random_dfas();
        test_output_hold();
        test_full_rate();

        $display("Sent %0d items over %0d random automata, checked %0d match results.",
                 items_sent, dfa_phases, results_seen);
        $display("start_state written %0d times; stalls, long hold and full rate covered.",
                 cfg_writes);
        if (errors == 0)
            $display("table_driven_dfa_matcher_tb passed");
        else
            $display("table_driven_dfa_matcher_tb failed");
        $finish;
    end

endmodule : table_driven_dfa_matcher_tb

@@ sim.f @@
rtl/dfam_pkg.sv
rtl/dfam_ram.sv
rtl/dfam_clear.sv
rtl/dfam_resq.sv
rtl/table_driven_dfa_matcher.sv
rtl/dfam_checker.sv
verif/table_driven_dfa_matcher_tb.sv
